// ===== rtl/rsfv_pkg.sv =====
// Shared types, constants and small decode functions for the radix string
// to fixed value unit. Has no dependencies; every rtl file but rsfv_queue uses it.
`default_nettype none

package rsfv_pkg;

    localparam int MAX_PRECISION = 8;

    localparam int SYM_W      = 8;
    localparam int RADIX_W    = 5;
    localparam int PREC_W     = 4;
    localparam int CNT_W      = 4;
    localparam int DIGIT_W    = 5;
    localparam int NUM_W      = 32;
    localparam int OUT_INT_W  = 48;
    localparam int FRAC_W     = 27;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Radix power 16^8 needs 33 bits; twice that is the first divisor.
    localparam int DEN_W  = 4 * MAX_PRECISION + 1;
    localparam int DSR_W  = DEN_W + 1;
    localparam int PROD_W = NUM_W + FRAC_W;
    localparam int DIVD_W = PROD_W + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRECISION = 1'b1;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [PREC_W-1:0]  PREC_RESET  = 4'd2;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_INVALID  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

    localparam logic [SYM_W-1:0] SYM_POINT  = 8'h2E;
    localparam logic [SYM_W-1:0] SYM_ZERO   = 8'h30;
    localparam logic [SYM_W-1:0] SYM_NINE   = 8'h39;
    localparam logic [SYM_W-1:0] SYM_UPPERA = 8'h41;
    localparam logic [SYM_W-1:0] SYM_UPPERF = 8'h46;

    localparam logic [DIGIT_W-1:0] DIGIT_NONE = 5'd16;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } t_in;

    typedef struct packed {
        logic [OUT_INT_W-1:0] integer_part;
        logic [FRAC_W-1:0]    fraction_scaled;
        logic [STAT_W-1:0]    status;
    } t_out;

    // Everything the back end needs about one finished string except the
    // integer accumulator, whose width is a top level parameter.
    typedef struct packed {
        logic [NUM_W-1:0]   num;
        logic [CNT_W-1:0]   cnt;
        logic [STAT_W-1:0]  err;
        logic [RADIX_W-1:0] radix;
        logic [PREC_W-1:0]  prec;
    } t_job;

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [SYM_W-1:0] sym);
        logic [DIGIT_W-1:0] d;
        d = DIGIT_NONE;
        if (sym >= SYM_ZERO && sym <= SYM_NINE) begin
            d = DIGIT_W'(sym - SYM_ZERO);
        end else if (sym >= SYM_UPPERA && sym <= SYM_UPPERF) begin
            d = DIGIT_W'(sym - SYM_UPPERA + 8'd10);
        end
        return d;
    endfunction

    function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] e;
        e = r;
        if (r < RADIX_MIN) begin
            e = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            e = RADIX_MAX;
        end
        return e;
    endfunction

    function automatic logic [PREC_W-1:0] eff_prec(input logic [PREC_W-1:0] p);
        logic [PREC_W-1:0] e;
        e = p;
        if (p > PREC_W'(MAX_PRECISION)) begin
            e = PREC_W'(MAX_PRECISION);
        end
        return e;
    endfunction

    function automatic logic [FRAC_W-1:0] pow10(input logic [PREC_W-1:0] p);
        logic [FRAC_W-1:0] v;
        unique case (p)
            4'd0:    v = 27'd1;
            4'd1:    v = 27'd10;
            4'd2:    v = 27'd100;
            4'd3:    v = 27'd1000;
            4'd4:    v = 27'd10000;
            4'd5:    v = 27'd100000;
            4'd6:    v = 27'd1000000;
            4'd7:    v = 27'd10000000;
            4'd8:    v = 27'd100000000;
            default: v = 27'd1;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/radix_string_to_fixed_value_unit.sv =====
// Top level of the radix string to fixed value unit: front end, job queue
// and back end. Depends on rsfv_pkg, rsfv_front, rsfv_queue, rsfv_back.
//
//   port group   dir  handshake              word
//   i_in_*       in   i_in_valid/o_in_ready  t_in: symbol, last
//   o_out_*      out  o_out_valid/i_out_ready t_out: integer_part, fraction_scaled, status
//   i_cfg_*      in   i_cfg_we               index 0 radix, index 1 precision
//
// The front end takes one character word per cycle while the job queue has room.
// A word marked last becomes a job; the back end takes the next job only once
// it is idle again, and runs the bit-serial divider twice per job.
// Two jobs can wait in the queue and one result in the output register.
// Reset is synchronous, active low, and clears all control state and the radix
// and precision registers to 10 and 2.
`default_nettype none

module radix_string_to_fixed_value_unit #(
    parameter int INTEGER_WIDTH = 48
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rsfv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rsfv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire rsfv_pkg::t_in                   i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output rsfv_pkg::t_out                       o_out_data
);

    localparam int JOB_W = $bits(rsfv_pkg::t_job);
    localparam int Q_W   = INTEGER_WIDTH + JOB_W;

    logic                     push;
    logic                     push_ready;
    rsfv_pkg::t_job           front_job;
    logic [INTEGER_WIDTH-1:0] front_acc;
    logic                     pop_valid;
    logic                     pop;
    logic [Q_W-1:0]           pop_data;
    rsfv_pkg::t_job           back_job;
    logic [INTEGER_WIDTH-1:0] back_acc;

    rsfv_front #(
        .INTEGER_WIDTH (INTEGER_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_job        (front_job),
        .o_job_acc    (front_acc)
    );

    rsfv_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_push_data  ({front_acc, front_job}),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_pop_data   (pop_data)
    );

    assign back_acc = pop_data[Q_W-1:JOB_W];
    assign back_job = pop_data[JOB_W-1:0];

    rsfv_back #(
        .INTEGER_WIDTH (INTEGER_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (pop_valid),
        .o_job_ready (pop),
        .i_job       (back_job),
        .i_job_acc   (back_acc),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== rtl/rsfv_front.sv =====
// Front end: configuration registers and per-character parsing of the digit
// string. Depends on rsfv_pkg; hands finished strings to the job queue.
`default_nettype none

module rsfv_front #(
    parameter int INTEGER_WIDTH = 48
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rsfv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rsfv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire rsfv_pkg::t_in                   i_in_data,
    output logic                                 o_push,
    input  wire logic                            i_push_ready,
    output rsfv_pkg::t_job                       o_job,
    output logic [INTEGER_WIDTH-1:0]             o_job_acc
);

    localparam int MAC_W  = INTEGER_WIDTH + rsfv_pkg::RADIX_W;
    localparam int FMAC_W = rsfv_pkg::NUM_W + rsfv_pkg::RADIX_W;
    localparam logic [INTEGER_WIDTH-1:0] INT_MAX = '1;

    logic [rsfv_pkg::RADIX_W-1:0] r_radix;
    logic [rsfv_pkg::PREC_W-1:0]  r_prec;
    logic [INTEGER_WIDTH-1:0]     r_acc,    n_acc;
    logic [rsfv_pkg::NUM_W-1:0]   r_num,    n_num;
    logic [rsfv_pkg::CNT_W-1:0]   r_cnt,    n_cnt;
    logic                         r_in_frac, n_in_frac;
    logic [rsfv_pkg::STAT_W-1:0]  r_err,    n_err;

    logic [rsfv_pkg::RADIX_W-1:0] radix;
    logic [rsfv_pkg::PREC_W-1:0]  prec;
    logic [rsfv_pkg::DIGIT_W-1:0] digit;
    logic [rsfv_pkg::DIGIT_W-1:0] frac_digit;
    logic                         bad_digit;
    logic [MAC_W-1:0]             int_mac;
    logic [FMAC_W-1:0]            frac_mac;
    logic                         fire;

    assign radix      = rsfv_pkg::eff_radix(r_radix);
    assign prec       = rsfv_pkg::eff_prec(r_prec);
    assign digit      = rsfv_pkg::digit_of(i_in_data.symbol);
    assign bad_digit  = (digit >= radix);
    assign frac_digit = bad_digit ? '0 : digit;
    assign int_mac    = MAC_W'(r_acc) * MAC_W'(radix) + MAC_W'(digit);
    assign frac_mac   = FMAC_W'(r_num) * FMAC_W'(radix) + FMAC_W'(frac_digit);

    assign o_in_ready = i_push_ready;
    assign fire       = i_in_valid && o_in_ready;

    always_comb begin
        n_acc     = r_acc;
        n_num     = r_num;
        n_cnt     = r_cnt;
        n_in_frac = r_in_frac;
        n_err     = r_err;
        if (!r_in_frac) begin
            if (i_in_data.symbol == rsfv_pkg::SYM_POINT) begin
                n_in_frac = 1'b1;
            end else if (bad_digit) begin
                if (r_err == rsfv_pkg::STAT_OK) begin
                    n_err = rsfv_pkg::STAT_INVALID;
                end
            end else if (int_mac > MAC_W'(INT_MAX)) begin
                n_acc = INT_MAX;
                if (r_err == rsfv_pkg::STAT_OK) begin
                    n_err = rsfv_pkg::STAT_OVERFLOW;
                end
            end else begin
                n_acc = int_mac[INTEGER_WIDTH-1:0];
            end
        end else if (r_cnt < prec) begin
            // A bad fraction digit still takes its position, as a zero.
            if (bad_digit && r_err == rsfv_pkg::STAT_OK) begin
                n_err = rsfv_pkg::STAT_INVALID;
            end
            n_num = frac_mac[rsfv_pkg::NUM_W-1:0];
            n_cnt = r_cnt + 1'b1;
        end
    end

    assign o_push       = fire && i_in_data.last;
    assign o_job.num    = n_num;
    assign o_job.cnt    = n_cnt;
    assign o_job.err    = n_err;
    assign o_job.radix  = radix;
    assign o_job.prec   = prec;
    assign o_job_acc    = n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= rsfv_pkg::RADIX_RESET;
            r_prec  <= rsfv_pkg::PREC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rsfv_pkg::CFG_RADIX:     r_radix <= i_cfg_data;
                rsfv_pkg::CFG_PRECISION: r_prec  <= i_cfg_data[rsfv_pkg::PREC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_num     <= '0;
            r_cnt     <= '0;
            r_in_frac <= 1'b0;
            r_err     <= rsfv_pkg::STAT_OK;
        end else if (fire) begin
            if (i_in_data.last) begin
                // The string is handed off; start the next one clean.
                r_acc     <= '0;
                r_num     <= '0;
                r_cnt     <= '0;
                r_in_frac <= 1'b0;
                r_err     <= rsfv_pkg::STAT_OK;
            end else begin
                r_acc     <= n_acc;
                r_num     <= n_num;
                r_cnt     <= n_cnt;
                r_in_frac <= n_in_frac;
                r_err     <= n_err;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rsfv_queue.sv =====
// Two-entry job queue between the parsing front end and the arithmetic
// back end. Depends on nothing but its data width parameter.
`default_nettype none

module rsfv_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_push_ready,
    input  wire logic [DATA_W-1:0] i_push_data,
    output logic                   o_pop_valid,
    input  wire logic              i_pop,
    output logic [DATA_W-1:0]      o_pop_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_slot[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rsfv_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by both divisions
// of the back end. Depends on rsfv_pkg for the operand widths.
`default_nettype none

module rsfv_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [rsfv_pkg::DIVD_W-1:0] i_dividend,
    input  wire logic [rsfv_pkg::DSR_W-1:0]  i_divisor,
    output logic                             o_done,
    output logic [rsfv_pkg::DIVD_W-1:0]      o_quot,
    output logic [rsfv_pkg::DSR_W-1:0]       o_rem
);

    localparam int DW    = rsfv_pkg::DIVD_W;
    localparam int SW    = rsfv_pkg::DSR_W;
    localparam int STEPW = $clog2(DW);

    logic             r_busy;
    logic             r_done;
    logic [STEPW-1:0] r_step;
    logic [DW-1:0]    r_quo;
    logic [SW-1:0]    r_rem;
    logic [SW-1:0]    r_dsr;
    logic [SW:0]      trial;
    logic [SW:0]      diff;
    logic             fits;

    // The dividend shifts out of the top of r_quo while quotient bits
    // shift in at the bottom.
    assign trial = {r_rem, r_quo[DW-1]};
    assign diff  = trial - {1'b0, r_dsr};
    assign fits  = (trial >= {1'b0, r_dsr});

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == STEPW'(DW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step <= '0;
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_dsr  <= i_divisor;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            r_rem  <= fits ? diff[SW-1:0] : trial[SW-1:0];
            r_quo  <= {r_quo[DW-2:0], fits};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rsfv_back.sv =====
// Back end: radix power, fraction scaling, rounding and carry fold for one
// finished string, plus the output register. Depends on rsfv_pkg, rsfv_div.
`default_nettype none

module rsfv_back #(
    parameter int INTEGER_WIDTH = 48
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_job_valid,
    output logic                          o_job_ready,
    input  wire rsfv_pkg::t_job           i_job,
    input  wire logic [INTEGER_WIDTH-1:0] i_job_acc,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output rsfv_pkg::t_out                o_out_data
);

    localparam int DEN_W  = rsfv_pkg::DEN_W;
    localparam int DSR_W  = rsfv_pkg::DSR_W;
    localparam int DIVD_W = rsfv_pkg::DIVD_W;
    localparam int PROD_W = rsfv_pkg::PROD_W;
    localparam int FRAC_W = rsfv_pkg::FRAC_W;
    localparam int DM_W   = DEN_W + rsfv_pkg::RADIX_W;
    localparam int SUM_W  = ((INTEGER_WIDTH > DIVD_W) ? INTEGER_WIDTH : DIVD_W) + 1;
    localparam int EXT_W  = (INTEGER_WIDTH > rsfv_pkg::OUT_INT_W) ?
                            INTEGER_WIDTH : rsfv_pkg::OUT_INT_W;
    localparam logic [INTEGER_WIDTH-1:0] INT_MAX = '1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_POW  = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_LD1  = 7'b0001000,
        S_DIV1 = 7'b0010000,
        S_DIV2 = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_back_state;

    t_back_state                  r_state;
    logic [INTEGER_WIDTH-1:0]     r_acc;
    logic [rsfv_pkg::NUM_W-1:0]   r_num;
    logic [rsfv_pkg::CNT_W-1:0]   r_k;
    logic [rsfv_pkg::STAT_W-1:0]  r_err;
    logic [rsfv_pkg::RADIX_W-1:0] r_radix;
    logic [rsfv_pkg::PREC_W-1:0]  r_prec;
    logic [DEN_W-1:0]             r_den;
    logic [PROD_W-1:0]            r_prod;
    logic [DIVD_W-1:0]            r_carry;
    logic [FRAC_W-1:0]            r_frac;
    logic                         r_out_valid;
    rsfv_pkg::t_out               r_out;

    logic [FRAC_W-1:0]            scale;
    logic [DM_W-1:0]              den_mul;
    logic                         div_start;
    logic [DIVD_W-1:0]            div_dividend;
    logic [DSR_W-1:0]             div_divisor;
    logic                         div_done;
    logic [DIVD_W-1:0]            div_quot;
    logic [DSR_W-1:0]             div_rem;
    logic                         out_free;
    logic [SUM_W-1:0]             sum;
    logic                         sum_ovf;
    logic [rsfv_pkg::STAT_W-1:0]  fin_err;
    logic [INTEGER_WIDTH-1:0]     fin_ip;
    logic [EXT_W-1:0]             ip_ext;

    assign scale   = rsfv_pkg::pow10(r_prec);
    assign den_mul = DM_W'(r_den) * DM_W'(r_radix);

    // First pass: round-half-up of num*scale/den as (2*num*scale + den)/(2*den).
    // Second pass splits that by scale into the integer carry and the fraction.
    assign div_start    = (r_state == S_LD1) || (r_state == S_DIV1 && div_done);
    assign div_dividend = (r_state == S_LD1) ?
                          DIVD_W'({r_prod, 1'b0}) + DIVD_W'(r_den) : div_quot;
    assign div_divisor  = (r_state == S_LD1) ? DSR_W'({r_den, 1'b0}) : DSR_W'(scale);

    rsfv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign out_free = !r_out_valid || i_out_ready;
    assign sum      = SUM_W'(r_acc) + SUM_W'(r_carry);
    assign sum_ovf  = (sum > SUM_W'(INT_MAX));
    assign fin_err  = (sum_ovf && r_err == rsfv_pkg::STAT_OK) ? rsfv_pkg::STAT_OVERFLOW : r_err;
    assign fin_ip   = sum_ovf ? INT_MAX : sum[INTEGER_WIDTH-1:0];
    assign ip_ext   = EXT_W'(fin_ip);

    assign o_job_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_job_valid) r_state <= S_POW;
                S_POW:  if (r_k == '0) r_state <= S_MUL;
                S_MUL:  r_state <= S_LD1;
                S_LD1:  r_state <= S_DIV1;
                S_DIV1: if (div_done) r_state <= S_DIV2;
                S_DIV2: if (div_done) r_state <= S_FIN;
                S_FIN:  if (out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_job_valid) begin
            r_acc   <= i_job_acc;
            r_num   <= i_job.num;
            r_k     <= i_job.cnt;
            r_err   <= i_job.err;
            r_radix <= i_job.radix;
            r_prec  <= i_job.prec;
            r_den   <= DEN_W'(1);
        end
        if (r_state == S_POW && r_k != '0) begin
            r_den <= den_mul[DEN_W-1:0];
            r_k   <= r_k - 1'b1;
        end
        if (r_state == S_MUL) begin
            r_prod <= PROD_W'(r_num) * PROD_W'(scale);
        end
        if (r_state == S_DIV2 && div_done) begin
            r_carry <= div_quot;
            r_frac  <= div_rem[FRAC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) begin
            r_out.status <= fin_err;
            if (fin_err == rsfv_pkg::STAT_INVALID) begin
                r_out.integer_part    <= '0;
                r_out.fraction_scaled <= '0;
            end else begin
                r_out.integer_part    <= ip_ext[rsfv_pkg::OUT_INT_W-1:0];
                r_out.fraction_scaled <= r_frac;
            end
        end
    end

`ifndef SYNTHESIS
    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV1 || r_state == S_DIV2))
        else $error("divider finished outside a division state");

    a_frac_below_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV2 && div_done) |-> (div_rem < DSR_W'(scale)))
        else $error("scaled fraction not below ten to the precision");

    a_invalid_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == rsfv_pkg::STAT_INVALID) |->
        (r_out.integer_part == '0 && r_out.fraction_scaled == '0))
        else $error("invalid result carries nonzero value fields");

    a_pow_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POW) |-> (r_k <= rsfv_pkg::CNT_W'(rsfv_pkg::MAX_PRECISION)))
        else $error("radix power count beyond the maximum precision");

    a_job_starts_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_job_ready && i_job_valid) |=> (r_state == S_POW))
        else $error("taken job did not start the radix power loop");
`endif

endmodule

`default_nettype wire
